// File: rtl/caf_pkg.sv
// ----------------------------------------------------------------------------
// caf_pkg
// Operation codes, flag positions and result type shared by the ALU files.
// ----------------------------------------------------------------------------
package caf_pkg;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_ADC   = 4'd1,
        OP_SUB   = 4'd2,
        OP_SBC   = 4'd3,
        OP_CP    = 4'd4,
        OP_AND   = 4'd5,
        OP_XOR   = 4'd6,
        OP_OR    = 4'd7,
        OP_INC8  = 4'd8,
        OP_DEC8  = 4'd9,
        OP_ADD16 = 4'd10,
        OP_ADDSP = 4'd11,
        OP_INC16 = 4'd12,
        OP_DEC16 = 4'd13
    } t_alu_op;

    // flag nibble bit positions
    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    typedef struct packed {
        logic [7:0]  r8;
        logic [15:0] r16;
        logic        z;
        logic        n;
        logic        h;
        logic        c;
    } t_alu_res;

endpackage

// File: rtl/cpu_alu_with_flags.sv
// ----------------------------------------------------------------------------
// cpu_alu_with_flags
// 8-bit CPU ALU with Z/N/H/C flags, input register, logic, result register.
// ----------------------------------------------------------------------------
// A word taken into the input reg moves on to the result reg once the result stage can load.
// Throughput: one word per cycle while the receiver does not stall; the single-pass adder/flag network sets it.
// o_s_tready drops in the same cycle the receiver stalls with both stages full.
// Reset (i_rst_n low, synchronous) empties both stages; data regs not reset.
module cpu_alu_with_flags
    import caf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // operation[3:0], acc_in[11:4], operand8[19:12], wide_left[35:20],
    // wide_right[51:36], flags_in[55:52]
    input  logic [55:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // result8[7:0], result16[23:8], zero_flag[24], subtract_flag[25],
    // half_flag[26], carry_flag[27], zero pad [31:28]
    output logic [31:0] o_m_tdata
);

    logic        r_in_valid;
    logic        n_in_valid;
    t_alu_op     r_in_op;
    logic [7:0]  r_in_acc;
    logic [7:0]  r_in_opnd;
    logic [15:0] r_in_wl;
    logic [15:0] r_in_wr;
    logic [3:0]  r_in_flags;
    logic        r_out_valid;
    logic        n_out_valid;
    t_alu_res    r_out;
    t_alu_res    core_res;
    logic        out_adv;
    logic        in_take;

    // result stage can load when empty or being drained this cycle
    assign out_adv    = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || out_adv;
    assign in_take    = i_s_tvalid && o_s_tready;

    assign n_in_valid  = in_take || (r_in_valid && !out_adv);
    assign n_out_valid = (r_in_valid && out_adv) || (r_out_valid && !i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op    <= t_alu_op'(i_s_tdata[3:0]);
            r_in_acc   <= i_s_tdata[11:4];
            r_in_opnd  <= i_s_tdata[19:12];
            r_in_wl    <= i_s_tdata[35:20];
            r_in_wr    <= i_s_tdata[51:36];
            r_in_flags <= i_s_tdata[55:52];
        end
        if (r_in_valid && out_adv) begin
            r_out <= core_res;
        end
    end

    caf_core u_core (
        .i_op    (r_in_op),
        .i_acc   (r_in_acc),
        .i_opnd  (r_in_opnd),
        .i_wl    (r_in_wl),
        .i_wr    (r_in_wr),
        .i_flags (r_in_flags),
        .o_res   (core_res)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out.c, r_out.h, r_out.n, r_out.z, r_out.r16, r_out.r8};

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_in_valid && !r_out_valid))
        else $error("pipeline not empty after reset");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_m_tready) |-> !o_s_tready)
        else $error("input accepted while both stages are stalled");

    a_cp_keeps_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_adv && r_in_op == OP_CP) |=> (r_out.r8 == $past(r_in_acc)))
        else $error("compare changed the accumulator");

    a_byte_ops_r16: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_adv && r_in_op < OP_ADD16) |=> (r_out.r16 == 16'd0))
        else $error("8-bit operation drove a 16-bit result");

    a_word_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_adv) |=> r_out_valid)
        else $error("computed word lost before result register");

endmodule

// File: rtl/caf_core.sv
// ----------------------------------------------------------------------------
// caf_core
// Combinational adder and flag network for one ALU operation.
// ----------------------------------------------------------------------------
module caf_core
    import caf_pkg::*;
(
    input  t_alu_op     i_op,
    input  logic [7:0]  i_acc,
    input  logic [7:0]  i_opnd,
    input  logic [15:0] i_wl,
    input  logic [15:0] i_wr,
    input  logic [3:0]  i_flags,
    output t_alu_res    o_res
);

    logic        cin;
    logic        use_c;
    logic [8:0]  add9;
    logic [4:0]  addh;
    logic [8:0]  sub9;
    logic [4:0]  subh;
    logic [7:0]  and8;
    logic [7:0]  xor8;
    logic [7:0]  or8;
    logic [7:0]  inc8;
    logic [7:0]  dec8;
    logic [16:0] add17;
    logic [12:0] add13;
    logic [15:0] sp16;
    logic [4:0]  sph;
    logic [8:0]  spc;

    assign cin   = i_flags[FLAG_C];
    assign use_c = cin & ((i_op == OP_ADC) | (i_op == OP_SBC));

    assign add9  = {1'b0, i_acc} + {1'b0, i_opnd} + {8'd0, use_c};
    assign addh  = {1'b0, i_acc[3:0]} + {1'b0, i_opnd[3:0]} + {4'd0, use_c};
    // borrow shows up in the top bit of the widened difference
    assign sub9  = {1'b0, i_acc} - {1'b0, i_opnd} - {8'd0, use_c};
    assign subh  = {1'b0, i_acc[3:0]} - {1'b0, i_opnd[3:0]} - {4'd0, use_c};
    assign and8  = i_acc & i_opnd;
    assign xor8  = i_acc ^ i_opnd;
    assign or8   = i_acc | i_opnd;
    assign inc8  = i_acc + 8'd1;
    assign dec8  = i_acc - 8'd1;
    assign add17 = {1'b0, i_wl} + {1'b0, i_wr};
    assign add13 = {1'b0, i_wl[11:0]} + {1'b0, i_wr[11:0]};
    assign sp16  = i_wl + {{8{i_opnd[7]}}, i_opnd};
    // SP+e8 flags come from unsigned low-byte carries
    assign sph   = {1'b0, i_wl[3:0]} + {1'b0, i_opnd[3:0]};
    assign spc   = {1'b0, i_wl[7:0]} + {1'b0, i_opnd};

    always_comb begin
        o_res.r8  = 8'd0;
        o_res.r16 = 16'd0;
        o_res.z   = i_flags[FLAG_Z];
        o_res.n   = i_flags[FLAG_N];
        o_res.h   = i_flags[FLAG_H];
        o_res.c   = i_flags[FLAG_C];
        case (i_op)
            OP_ADD, OP_ADC: begin
                o_res.r8 = add9[7:0];
                o_res.z  = (add9[7:0] == 8'd0);
                o_res.n  = 1'b0;
                o_res.h  = addh[4];
                o_res.c  = add9[8];
            end
            OP_SUB, OP_SBC, OP_CP: begin
                o_res.r8 = (i_op == OP_CP) ? i_acc : sub9[7:0];
                o_res.z  = (sub9[7:0] == 8'd0);
                o_res.n  = 1'b1;
                o_res.h  = subh[4];
                o_res.c  = sub9[8];
            end
            OP_AND: begin
                o_res.r8 = and8;
                o_res.z  = (and8 == 8'd0);
                o_res.n  = 1'b0;
                o_res.h  = 1'b1;
                o_res.c  = 1'b0;
            end
            OP_XOR: begin
                o_res.r8 = xor8;
                o_res.z  = (xor8 == 8'd0);
                o_res.n  = 1'b0;
                o_res.h  = 1'b0;
                o_res.c  = 1'b0;
            end
            OP_OR: begin
                o_res.r8 = or8;
                o_res.z  = (or8 == 8'd0);
                o_res.n  = 1'b0;
                o_res.h  = 1'b0;
                o_res.c  = 1'b0;
            end
            OP_INC8: begin
                o_res.r8 = inc8;
                o_res.z  = (inc8 == 8'd0);
                o_res.n  = 1'b0;
                o_res.h  = (i_acc[3:0] == 4'hF);
            end
            OP_DEC8: begin
                o_res.r8 = dec8;
                o_res.z  = (dec8 == 8'd0);
                o_res.n  = 1'b1;
                o_res.h  = (i_acc[3:0] == 4'h0);
            end
            OP_ADD16: begin
                o_res.r16 = add17[15:0];
                o_res.n   = 1'b0;
                o_res.h   = add13[12];
                o_res.c   = add17[16];
            end
            OP_ADDSP: begin
                o_res.r16 = sp16;
                o_res.z   = 1'b0;
                o_res.n   = 1'b0;
                o_res.h   = sph[4];
                o_res.c   = spc[8];
            end
            OP_INC16: begin
                o_res.r16 = i_wl + 16'd1;
            end
            OP_DEC16: begin
                o_res.r16 = i_wl - 16'd1;
            end
            default: begin
                // unassigned codes pass the accumulator, wide_left and flags through
                o_res.r8  = i_acc;
                o_res.r16 = i_wl;
            end
        endcase
    end

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 8-bit CPU ALU with Z/N/H/C flags. A queue-fed
// driver pushes operation words into the slave side. Each accepted word is run
// through a local flag and result predictor, and the expected result is queued.
// A monitor checks every result word field by field against that queue. The run
// goes through directed corners, then random words under several idle and stall
// mixes, with one long receiver hold-off to fill the pipe.
// ----------------------------------------------------------------------------
module tb_top
    import caf_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam int unsigned RAND_WORDS  = 240;

    typedef struct packed {
        logic [3:0]  op;
        logic [7:0]  acc;
        logic [7:0]  opd;
        logic [15:0] wl;
        logic [15:0] wr;
        logic [3:0]  flags;
    } t_alu_cmd;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        o_s_tready;
    // operation[3:0], acc_in[11:4], operand8[19:12], wide_left[35:20],
    // wide_right[51:36], flags_in[55:52]
    logic [55:0] s_tdata = '0;
    logic        o_m_tvalid;
    logic        m_tready = 1'b0;
    // result8[7:0], result16[23:8], zero_flag[24], subtract_flag[25],
    // half_flag[26], carry_flag[27], zero pad [31:28]
    logic [31:0] o_m_tdata;

    t_alu_cmd    cmd_q[$];
    t_alu_res    res_q[$];
    t_alu_cmd    cur_cmd;

    int unsigned src_idle_pct = 0;
    int unsigned snk_stall_pct = 0;
    logic        hold_start = 1'b0;
    int unsigned hold_cnt = 0;
    int unsigned cycle_cnt = 0;
    int unsigned sent_cnt = 0;
    int unsigned checked_cnt = 0;
    int unsigned mismatch_cnt = 0;

    cpu_alu_with_flags dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // expected result and flags for one operation word
    function automatic t_alu_res alu_predict(t_alu_cmd w);
        t_alu_res    r;
        logic        cin;
        logic        t;
        logic [8:0]  s9;
        logic [4:0]  s5;
        logic [16:0] s17;
        logic [12:0] s13;
        cin = w.flags[FLAG_C];
        t   = 1'b0;
        r.r8  = '0;
        r.r16 = '0;
        r.z = w.flags[FLAG_Z];
        r.n = w.flags[FLAG_N];
        r.h = w.flags[FLAG_H];
        r.c = w.flags[FLAG_C];
        case (w.op)
            OP_ADD, OP_ADC: begin
                t    = (w.op == OP_ADC) ? cin : 1'b0;
                s9   = {1'b0, w.acc} + {1'b0, w.opd} + {8'd0, t};
                s5   = {1'b0, w.acc[3:0]} + {1'b0, w.opd[3:0]} + {4'd0, t};
                r.r8 = s9[7:0];
                r.z  = (s9[7:0] == 8'd0);
                r.n  = 1'b0;
                r.h  = s5[4];
                r.c  = s9[8];
            end
            OP_SUB, OP_SBC, OP_CP: begin
                t    = (w.op == OP_SBC) ? cin : 1'b0;
                // bit 8 / bit 4 go high exactly when the difference is negative
                s9   = {1'b0, w.acc} - {1'b0, w.opd} - {8'd0, t};
                s5   = {1'b0, w.acc[3:0]} - {1'b0, w.opd[3:0]} - {4'd0, t};
                r.r8 = (w.op == OP_CP) ? w.acc : s9[7:0];
                r.z  = (s9[7:0] == 8'd0);
                r.n  = 1'b1;
                r.h  = s5[4];
                r.c  = s9[8];
            end
            OP_AND: begin
                r.r8 = w.acc & w.opd;
                r.z  = (r.r8 == 8'd0);
                r.n  = 1'b0;
                r.h  = 1'b1;
                r.c  = 1'b0;
            end
            OP_XOR, OP_OR: begin
                r.r8 = (w.op == OP_XOR) ? (w.acc ^ w.opd) : (w.acc | w.opd);
                r.z  = (r.r8 == 8'd0);
                r.n  = 1'b0;
                r.h  = 1'b0;
                r.c  = 1'b0;
            end
            OP_INC8: begin
                r.r8 = w.acc + 8'd1;
                r.z  = (r.r8 == 8'd0);
                r.n  = 1'b0;
                r.h  = (w.acc[3:0] == 4'hF);
            end
            OP_DEC8: begin
                r.r8 = w.acc - 8'd1;
                r.z  = (r.r8 == 8'd0);
                r.n  = 1'b1;
                r.h  = (w.acc[3:0] == 4'h0);
            end
            OP_ADD16: begin
                s17   = {1'b0, w.wl} + {1'b0, w.wr};
                s13   = {1'b0, w.wl[11:0]} + {1'b0, w.wr[11:0]};
                r.r16 = s17[15:0];
                r.n   = 1'b0;
                r.h   = s13[12];
                r.c   = s17[16];
            end
            OP_ADDSP: begin
                // flags come from unsigned low-byte sums, result from signed add
                s9    = {1'b0, w.wl[7:0]} + {1'b0, w.opd};
                s5    = {1'b0, w.wl[3:0]} + {1'b0, w.opd[3:0]};
                r.r16 = w.wl + {{8{w.opd[7]}}, w.opd};
                r.z   = 1'b0;
                r.n   = 1'b0;
                r.h   = s5[4];
                r.c   = s9[8];
            end
            OP_INC16: r.r16 = w.wl + 16'd1;
            OP_DEC16: r.r16 = w.wl - 16'd1;
            default: begin
                // undefined codes pass acc, wl and the flags through
                r.r8  = w.acc;
                r.r16 = w.wl;
            end
        endcase
        return r;
    endfunction

    function automatic t_alu_cmd mk_cmd(logic [3:0] op, logic [7:0] a, logic [7:0] b,
                                        logic [15:0] wl, logic [15:0] wr,
                                        logic [3:0] f);
        t_alu_cmd w;
        w.op = op;
        w.acc = a;
        w.opd = b;
        w.wl = wl;
        w.wr = wr;
        w.flags = f;
        return w;
    endfunction

    function automatic logic [7:0] pick_byte();
        logic [7:0] corners [6];
        corners = '{8'h00, 8'hFF, 8'h0F, 8'h10, 8'h80, 8'h7F};
        if ($urandom_range(3) == 0)
            return corners[$urandom_range(5)];
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [15:0] pick_half();
        logic [15:0] corners [6];
        corners = '{16'h0000, 16'hFFFF, 16'h0FFF, 16'h00FF, 16'hFF00, 16'h1000};
        if ($urandom_range(3) == 0)
            return corners[$urandom_range(5)];
        return 16'($urandom_range(65535));
    endfunction

    task automatic queue_random(int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            cmd_q.push_back(mk_cmd(4'($urandom_range(15)), pick_byte(), pick_byte(),
                                   pick_half(), pick_half(), 4'($urandom_range(15))));
    endtask

    // wait until every word is accepted and every result has come back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (cmd_q.size() != 0 || s_tvalid || res_q.size() != 0);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                res_q.push_back(alu_predict(cur_cmd));
                sent_cnt++;
            end
            if (!s_tvalid || o_s_tready) begin
                if (cmd_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    cur_cmd = cmd_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {cur_cmd.flags, cur_cmd.wr, cur_cmd.wl,
                                cur_cmd.opd, cur_cmd.acc, cur_cmd.op};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver hold-off counter
    always @(posedge i_clk) begin
        if (hold_start)
            hold_cnt <= HOLD_CYCLES;
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
    end

    // monitor and checker
    always @(posedge i_clk) begin
        t_alu_res got;
        t_alu_res want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                got.r8  = o_m_tdata[7:0];
                got.r16 = o_m_tdata[23:8];
                got.z   = o_m_tdata[24];
                got.n   = o_m_tdata[25];
                got.h   = o_m_tdata[26];
                got.c   = o_m_tdata[27];
                if (res_q.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, o_m_tdata);
                    mismatch_cnt++;
                end else begin
                    want = res_q.pop_front();
                    checked_cnt++;
                    if (got.r8 !== want.r8) begin
                        $display("%0t: result8 exp %h got %h", $time, want.r8, got.r8);
                        mismatch_cnt++;
                    end
                    if (got.r16 !== want.r16) begin
                        $display("%0t: result16 exp %h got %h", $time, want.r16, got.r16);
                        mismatch_cnt++;
                    end
                    if (got.z !== want.z) begin
                        $display("%0t: zero_flag exp %b got %b", $time, want.z, got.z);
                        mismatch_cnt++;
                    end
                    if (got.n !== want.n) begin
                        $display("%0t: subtract_flag exp %b got %b", $time, want.n, got.n);
                        mismatch_cnt++;
                    end
                    if (got.h !== want.h) begin
                        $display("%0t: half_flag exp %b got %b", $time, want.h, got.h);
                        mismatch_cnt++;
                    end
                    if (got.c !== want.c) begin
                        $display("%0t: carry_flag exp %b got %b", $time, want.c, got.c);
                        mismatch_cnt++;
                    end
                end
            end
            m_tready <= (hold_cnt == 0) && ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still pending", $time, res_q.size());
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        // directed corners: carries, borrows, zero results, nibble edges
        cmd_q.push_back(mk_cmd(OP_ADD,   8'hFF, 8'h01, 16'h0000, 16'h0000, 4'h0));
        cmd_q.push_back(mk_cmd(OP_ADD,   8'h00, 8'h00, 16'hFFFF, 16'hFFFF, 4'hF));
        cmd_q.push_back(mk_cmd(OP_ADC,   8'hFF, 8'h00, 16'h0000, 16'h0000, 4'h1));
        cmd_q.push_back(mk_cmd(OP_ADC,   8'h0F, 8'h00, 16'h0000, 16'h0000, 4'h1));
        cmd_q.push_back(mk_cmd(OP_SUB,   8'h42, 8'h42, 16'h0000, 16'h0000, 4'h0));
        cmd_q.push_back(mk_cmd(OP_SUB,   8'h10, 8'h01, 16'h0000, 16'h0000, 4'hF));
        cmd_q.push_back(mk_cmd(OP_SBC,   8'h00, 8'hFF, 16'h0000, 16'h0000, 4'h1));
        cmd_q.push_back(mk_cmd(OP_SBC,   8'h01, 8'h00, 16'h0000, 16'h0000, 4'h1));
        cmd_q.push_back(mk_cmd(OP_CP,    8'h80, 8'h81, 16'h0000, 16'h0000, 4'h0));
        cmd_q.push_back(mk_cmd(OP_CP,    8'hFF, 8'hFF, 16'h0000, 16'h0000, 4'hF));
        cmd_q.push_back(mk_cmd(OP_AND,   8'hF0, 8'h0F, 16'h0000, 16'h0000, 4'h0));
        cmd_q.push_back(mk_cmd(OP_AND,   8'hFF, 8'hFF, 16'h0000, 16'h0000, 4'hF));
        cmd_q.push_back(mk_cmd(OP_XOR,   8'hAA, 8'hAA, 16'h0000, 16'h0000, 4'hF));
        cmd_q.push_back(mk_cmd(OP_OR,    8'h00, 8'h00, 16'h0000, 16'h0000, 4'h7));
        cmd_q.push_back(mk_cmd(OP_INC8,  8'hFF, 8'h00, 16'h0000, 16'h0000, 4'h1));
        cmd_q.push_back(mk_cmd(OP_INC8,  8'h0F, 8'h00, 16'h0000, 16'h0000, 4'h0));
        cmd_q.push_back(mk_cmd(OP_DEC8,  8'h00, 8'h00, 16'h0000, 16'h0000, 4'h1));
        cmd_q.push_back(mk_cmd(OP_DEC8,  8'h01, 8'h00, 16'h0000, 16'h0000, 4'h0));
        cmd_q.push_back(mk_cmd(OP_ADD16, 8'h00, 8'h00, 16'hFFFF, 16'h0001, 4'h8));
        cmd_q.push_back(mk_cmd(OP_ADD16, 8'h00, 8'h00, 16'h0FFF, 16'h0001, 4'h0));
        cmd_q.push_back(mk_cmd(OP_ADDSP, 8'h00, 8'h80, 16'h0000, 16'h0000, 4'hF));
        cmd_q.push_back(mk_cmd(OP_ADDSP, 8'h00, 8'hFF, 16'h00FF, 16'h0000, 4'hF));
        cmd_q.push_back(mk_cmd(OP_ADDSP, 8'h00, 8'h01, 16'hFFFF, 16'h0000, 4'h0));
        cmd_q.push_back(mk_cmd(OP_INC16, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 4'hA));
        cmd_q.push_back(mk_cmd(OP_DEC16, 8'h00, 8'h00, 16'h0000, 16'h0000, 4'h5));
        cmd_q.push_back(mk_cmd(4'd14,    8'hA5, 8'h5A, 16'h1234, 16'hFFFF, 4'h9));
        cmd_q.push_back(mk_cmd(4'd15,    8'h5A, 8'hA5, 16'hEDCB, 16'h0000, 4'h6));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_drained();

        // back to back, no idling
        queue_random(RAND_WORDS);
        wait_drained();

        // sender idle most cycles
        src_idle_pct = 55;
        queue_random(RAND_WORDS);
        wait_drained();

        // receiver stalls most cycles
        src_idle_pct = 0;
        snk_stall_pct = 55;
        queue_random(RAND_WORDS);
        wait_drained();

        // light idling on both sides
        src_idle_pct = 6;
        snk_stall_pct = 6;
        queue_random(RAND_WORDS);
        wait_drained();

        // long receiver hold-off while the sender keeps offering: pipe fills
        src_idle_pct = 0;
        snk_stall_pct = 0;
        @(posedge i_clk);
        hold_start <= 1'b1;
        @(posedge i_clk);
        hold_start <= 1'b0;
        queue_random(RAND_WORDS);
        wait_drained();

        // stray results would show up here
        repeat (8) @(negedge i_clk);
        $display("tb_top: %0d words sent, %0d results checked, %0d mismatches",
                 sent_cnt, checked_cnt, mismatch_cnt);
        $display("tb_top: covered directed corners, random words, idle/stall mixes, backpressure");
        if (mismatch_cnt == 0 && res_q.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/caf_pkg.sv
rtl/caf_core.sv
rtl/cpu_alu_with_flags.sv
verif/tb_top.sv
